>>> design/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg
// shared types and constants for the button edge and auto-repeat block
// ----------------------------------------------------------------------------
package bea_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int AXIS_WIDTH  = 16;
   localparam int CFG_WIDTH   = 15;
   localparam int COUNT_WIDTH = 16;
   localparam int INDEX_WIDTH = 3;

   localparam logic [INDEX_WIDTH-1:0] CSR_STICK_DEADZONE = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] CSR_REPEAT_DELAY   = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] CSR_REPEAT_PERIOD  = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] CSR_DPAD_MASK      = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] CSR_STICK_H_MASK   = 3'd4;
   localparam logic [INDEX_WIDTH-1:0] CSR_STICK_V_MASK   = 3'd5;

   localparam logic [CFG_WIDTH-1:0] DEADZONE_RESET = 15'd4096;
   localparam logic [CFG_WIDTH-1:0] DELAY_RESET    = 15'd20;
   localparam logic [CFG_WIDTH-1:0] PERIOD_RESET   = 15'd5;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]  stick_deadzone;
      logic [CFG_WIDTH-1:0]  repeat_delay;
      logic [CFG_WIDTH-1:0]  repeat_period;
      logic [WORD_WIDTH-1:0] dpad_mask;
      logic [WORD_WIDTH-1:0] stick_horizontal_mask;
      logic [WORD_WIDTH-1:0] stick_vertical_mask;
   } cfg_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] repeat_pulse;
      logic [WORD_WIDTH-1:0] pressed_now;
      logic [WORD_WIDTH-1:0] held_last_frame;
      logic [WORD_WIDTH-1:0] held_filtered;
   } rsp_type;

endpackage

>>> design/bea_filter.sv
// ----------------------------------------------------------------------------
// bea_filter
// stick deadzone and direction pad versus stick exclusivity on the held word
// ----------------------------------------------------------------------------
module bea_filter (
   input  bea_pkg::cfg_type                    cfg,
   input  logic [bea_pkg::WORD_WIDTH-1:0]      held_raw,
   input  logic signed [bea_pkg::AXIS_WIDTH-1:0] stick_x,
   input  logic signed [bea_pkg::AXIS_WIDTH-1:0] stick_y,
   input  logic [bea_pkg::WORD_WIDTH-1:0]      prev_held,
   output logic [bea_pkg::WORD_WIDTH-1:0]      held_filtered
);

   logic [bea_pkg::AXIS_WIDTH-1:0] mag_x;
   logic [bea_pkg::AXIS_WIDTH-1:0] mag_y;
   logic                           dead_x;
   logic                           dead_y;
   logic [bea_pkg::WORD_WIDTH-1:0] stick_mask;
   logic [bea_pkg::WORD_WIDTH-1:0] held_dz;
   logic                           pad_now;
   logic                           pad_prev;
   logic                           stick_prev;

   // most negative code maps to 0x8000, read unsigned as its true magnitude
   assign mag_x = stick_x[bea_pkg::AXIS_WIDTH-1] ? (~stick_x + 1'b1) : stick_x;
   assign mag_y = stick_y[bea_pkg::AXIS_WIDTH-1] ? (~stick_y + 1'b1) : stick_y;

   assign dead_x = mag_x < {1'b0, cfg.stick_deadzone};
   assign dead_y = mag_y < {1'b0, cfg.stick_deadzone};

   assign stick_mask = cfg.stick_horizontal_mask | cfg.stick_vertical_mask;

   assign held_dz = held_raw
                  & ~(dead_x ? cfg.stick_horizontal_mask : '0)
                  & ~(dead_y ? cfg.stick_vertical_mask : '0);

   assign pad_now    = |(held_dz & cfg.dpad_mask);
   assign pad_prev   = |(prev_held & cfg.dpad_mask);
   assign stick_prev = |(prev_held & stick_mask);

   always_comb begin
      priority if (pad_now) begin
         held_filtered = stick_prev ? (held_dz & ~cfg.dpad_mask) : (held_dz & ~stick_mask);
      end else begin
         held_filtered = pad_prev ? (held_dz & ~stick_mask) : (held_dz & ~cfg.dpad_mask);
      end
   end

endmodule

>>> design/bea_lane.sv
// ----------------------------------------------------------------------------
// bea_lane
// per-button hold counter with auto-repeat pulse
// ----------------------------------------------------------------------------
module bea_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             held,
   input  logic                             pressed,
   input  logic [bea_pkg::COUNT_WIDTH-1:0]  threshold,
   input  logic [bea_pkg::CFG_WIDTH-1:0]    repeat_period,
   output logic                             pulse
);

   logic [bea_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [bea_pkg::COUNT_WIDTH-1:0] count_in;
   logic [bea_pkg::COUNT_WIDTH-1:0] count_base;
   logic [bea_pkg::COUNT_WIDTH-1:0] count_inc;
   logic                            fire;

   assign count_base = pressed ? '0 : count_ff;
   assign count_inc  = count_base + 1'b1;
   assign fire       = count_inc >= threshold;
   assign count_in   = fire ? (count_inc - {1'b0, repeat_period}) : count_inc;
   assign pulse      = held & fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance && held) begin
         count_ff <= count_in;
      end
   end

endmodule

>>> design/bea_skid.sv
// ----------------------------------------------------------------------------
// bea_skid
// output register with a skid entry so the input side keeps moving
// ----------------------------------------------------------------------------
module bea_skid #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             skid_valid_ff;
   logic [WIDTH-1:0] skid_data_ff;
   logic             out_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid && in_ready) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

>>> design/button_edge_and_autorepeat.sv
// ----------------------------------------------------------------------------
// button_edge_and_autorepeat
// per-frame button filter, edge detect and auto-repeat
// ----------------------------------------------------------------------------
// One frame sample is taken per clock cycle while req_tready is high; its
// result is registered in the rsp output stage, whose two entries let the
// req side take one more sample while rsp is stalled. The rate is
// set by the per-button counter lanes, each doing one increment, compare and
// subtract per cycle, and by the previous held word fed back to the filter.
// No clearing pass is needed after reset. Configuration writes are taken at
// any time and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module button_edge_and_autorepeat #(
   parameter int BUTTON_COUNT = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: held_raw[31:0], stick_x[47:32], stick_y[63:48]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,
   // rsp_tdata: held_filtered, held_last_frame, pressed_now, repeat_pulse
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [127:0]                       rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bea_pkg::INDEX_WIDTH-1:0]    csr_index,
   input  logic [bea_pkg::WORD_WIDTH-1:0]     csr_data
);

   localparam int LANE_COUNT = (BUTTON_COUNT < bea_pkg::WORD_WIDTH) ?
                               BUTTON_COUNT : bea_pkg::WORD_WIDTH;

   bea_pkg::cfg_type               cfg_ff;
   logic [bea_pkg::WORD_WIDTH-1:0] prev_ff;
   logic [bea_pkg::WORD_WIDTH-1:0] held;
   logic [bea_pkg::WORD_WIDTH-1:0] pressed;
   logic [bea_pkg::WORD_WIDTH-1:0] lane_pulse;
   logic [bea_pkg::COUNT_WIDTH-1:0] threshold;
   logic                           req_xfer;
   bea_pkg::rsp_type               rsp_next;
   bea_pkg::rsp_type               rsp_held;

   assign csr_ready = 1'b1;
   assign req_xfer  = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_deadzone        <= bea_pkg::DEADZONE_RESET;
         cfg_ff.repeat_delay          <= bea_pkg::DELAY_RESET;
         cfg_ff.repeat_period         <= bea_pkg::PERIOD_RESET;
         cfg_ff.dpad_mask             <= '0;
         cfg_ff.stick_horizontal_mask <= '0;
         cfg_ff.stick_vertical_mask   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bea_pkg::CSR_STICK_DEADZONE: begin
               cfg_ff.stick_deadzone <= csr_data[bea_pkg::CFG_WIDTH-1:0];
            end
            bea_pkg::CSR_REPEAT_DELAY: begin
               cfg_ff.repeat_delay <= csr_data[bea_pkg::CFG_WIDTH-1:0];
            end
            bea_pkg::CSR_REPEAT_PERIOD: begin
               cfg_ff.repeat_period <= csr_data[bea_pkg::CFG_WIDTH-1:0];
            end
            bea_pkg::CSR_DPAD_MASK:    cfg_ff.dpad_mask             <= csr_data;
            bea_pkg::CSR_STICK_H_MASK: cfg_ff.stick_horizontal_mask <= csr_data;
            bea_pkg::CSR_STICK_V_MASK: cfg_ff.stick_vertical_mask   <= csr_data;
            default: ;
         endcase
      end
   end

   bea_filter u_filter (
      .cfg           (cfg_ff),
      .held_raw      (req_tdata[31:0]),
      .stick_x       (req_tdata[47:32]),
      .stick_y       (req_tdata[63:48]),
      .prev_held     (prev_ff),
      .held_filtered (held)
   );

   assign pressed   = held & ~prev_ff;
   assign threshold = {1'b0, cfg_ff.repeat_delay} + {1'b0, cfg_ff.repeat_period};

   for (genvar i = 0; i < bea_pkg::WORD_WIDTH; i++) begin : g_lane
      if (i < LANE_COUNT) begin : g_on
         bea_lane u_lane (
            .clock         (clock),
            .reset         (reset),
            .advance       (req_xfer),
            .held          (held[i]),
            .pressed       (pressed[i]),
            .threshold     (threshold),
            .repeat_period (cfg_ff.repeat_period),
            .pulse         (lane_pulse[i])
         );
      end else begin : g_off
         assign lane_pulse[i] = 1'b0;
      end
   end

   // merge of the lane pulses with the edge bits
   assign rsp_next.held_filtered   = held;
   assign rsp_next.held_last_frame = prev_ff;
   assign rsp_next.pressed_now     = pressed;
   assign rsp_next.repeat_pulse    = (pressed | lane_pulse) & held;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (req_xfer) begin
         prev_ff <= held;
      end
   end

   bea_skid #(
      .WIDTH ($bits(bea_pkg::rsp_type))
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (rsp_next),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_held)
   );

   assign rsp_tdata = rsp_held;

   a_pressed_in_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_held.pressed_now & ~rsp_held.held_filtered) == '0))
      else $error("pressed bit without held bit");

   a_pressed_new: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_held.pressed_now & rsp_held.held_last_frame) == '0))
      else $error("pressed bit was already held");

   a_pulse_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_held.pressed_now & ~rsp_held.repeat_pulse) == '0)
                  && ((rsp_held.repeat_pulse & ~rsp_held.held_filtered) == '0))
      else $error("repeat pulse inconsistent with held or pressed");

   a_prev_tracks: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (prev_ff == $past(held)))
      else $error("previous held word not updated on transfer");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

endmodule
